[rtl/gof_pkg.sv]
package gof_pkg;

  localparam int GOF_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_SHIFT,
    STEP_REDUCE,
    STEP_EMIT
  } gof_step_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SHIFT,
    OP_REDUCE,
    OP_EMIT
  } gof_op_t;

  typedef enum logic [1:0] {
    COND_IN_VALID,
    COND_ALL_EVEN,
    COND_LAST_DONE,
    COND_OUT_FREE
  } gof_cond_t;

  typedef struct packed {
    gof_op_t   op;
    gof_cond_t cond;
    logic      gate;
    gof_step_t tgt_true;
    gof_step_t tgt_false;
  } gof_uword_t;

  typedef struct packed {
    logic all_even;
    logic last_done;
    logic out_free;
  } gof_flags_t;

  typedef struct packed {
    gof_op_t op;
    logic    fire;
  } gof_ctrl_t;

  function automatic gof_uword_t gof_ucode(gof_step_t step);
    gof_uword_t w;
    unique case (step)
      STEP_IDLE:   w = '{OP_LOAD,   COND_IN_VALID,  1'b1, STEP_SHIFT,  STEP_IDLE};
      STEP_SHIFT:  w = '{OP_SHIFT,  COND_ALL_EVEN,  1'b1, STEP_SHIFT,  STEP_REDUCE};
      STEP_REDUCE: w = '{OP_REDUCE, COND_LAST_DONE, 1'b0, STEP_EMIT,   STEP_REDUCE};
      STEP_EMIT:   w = '{OP_EMIT,   COND_OUT_FREE,  1'b1, STEP_IDLE,   STEP_EMIT};
      default:     w = '{OP_LOAD,   COND_IN_VALID,  1'b1, STEP_SHIFT,  STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/gof_seq.sv]
module gof_seq
  import gof_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  gof_flags_t flags,
  output gof_ctrl_t  ctrl,
  output logic       in_stall
);

  gof_step_t  pc_r, pc_nxt;
  gof_uword_t uword;
  logic       cond_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    uword = gof_ucode(pc_r);
    unique case (uword.cond)
      COND_IN_VALID:  cond_hit = in_valid;
      COND_ALL_EVEN:  cond_hit = flags.all_even;
      COND_LAST_DONE: cond_hit = flags.last_done;
      COND_OUT_FREE:  cond_hit = flags.out_free;
      default:        cond_hit = 1'b0;
    endcase
    pc_nxt    = cond_hit ? uword.tgt_true : uword.tgt_false;
    ctrl.op   = uword.op;
    ctrl.fire = !uword.gate || cond_hit;
    in_stall  = (pc_r != STEP_IDLE);
  end

endmodule

[rtl/gof_dp.sv]
module gof_dp
  import gof_pkg::*;
#(
  parameter int WIDTH = GOF_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gof_ctrl_t        ctrl,
  input  logic [WIDTH-1:0] in_operand_a,
  input  logic [WIDTH-1:0] in_operand_b,
  input  logic [WIDTH-1:0] in_operand_c,
  input  logic [WIDTH-1:0] in_operand_d,
  input  logic             out_stall,
  output gof_flags_t       flags,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_divisor
);

  localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] g_r, g_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;
  logic [WIDTH-1:0] q0_r, q0_nxt;
  logic [WIDTH-1:0] q1_r, q1_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_divisor_r, out_divisor_nxt;
  logic [WIDTH-1:0] all_or;
  logic             zero_pair;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    g_r           <= g_nxt;
    y_r           <= y_nxt;
    q0_r          <= q0_nxt;
    q1_r          <= q1_nxt;
    cnt_r         <= cnt_nxt;
    k_r           <= k_nxt;
    out_divisor_r <= out_divisor_nxt;
  end

  always_comb begin
    all_or          = g_r | y_r | q0_r | q1_r;
    zero_pair       = (g_r == '0) || (y_r == '0);
    flags.all_even  = (all_or != '0) && !all_or[0];
    flags.last_done = zero_pair && (cnt_r == 2'd0);
    flags.out_free  = !out_valid_r || !out_stall;

    g_nxt           = g_r;
    y_nxt           = y_r;
    q0_nxt          = q0_r;
    q1_nxt          = q1_r;
    cnt_nxt         = cnt_r;
    k_nxt           = k_r;
    out_divisor_nxt = out_divisor_r;
    out_valid_nxt   = out_valid_r && out_stall;

    if (ctrl.fire) begin
      case (ctrl.op)
        OP_LOAD: begin
          g_nxt   = in_operand_a;
          y_nxt   = in_operand_b;
          q0_nxt  = in_operand_c;
          q1_nxt  = in_operand_d;
          cnt_nxt = 2'd2;
          k_nxt   = '0;
        end
        OP_SHIFT: begin
          g_nxt  = g_r >> 1;
          y_nxt  = y_r >> 1;
          q0_nxt = q0_r >> 1;
          q1_nxt = q1_r >> 1;
          k_nxt  = k_r + KW'(1);
        end
        OP_REDUCE: begin
          // common odd factor is invariant, so halving any even value is safe
          if (zero_pair) begin
            g_nxt = g_r | y_r;
            if (cnt_r != 2'd0) begin
              y_nxt   = q0_r;
              q0_nxt  = q1_r;
              cnt_nxt = cnt_r - 2'd1;
            end
          end else if (!g_r[0]) begin
            g_nxt = g_r >> 1;
          end else if (!y_r[0]) begin
            y_nxt = y_r >> 1;
          end else if (g_r >= y_r) begin
            g_nxt = g_r - y_r;
          end else begin
            y_nxt = y_r - g_r;
          end
        end
        OP_EMIT: begin
          out_divisor_nxt = g_r << k_r;
          out_valid_nxt   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_divisor = out_divisor_r;

endmodule

[rtl/gcd_of_four_unit.sv]
// Timing: data dependent from input transfer to result valid, set by the
//   binary GCD loop, which performs one step per cycle.
// Throughput: one item at a time; the next input is taken once the result is
//   loaded into the output register, which holds it until transferred.
// Reset: synchronous active-low rst_n returns the sequencer to idle and clears out_valid.
module gcd_of_four_unit
  import gof_pkg::*;
#(
  parameter int WIDTH = GOF_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] in_operand_a,
  input  logic [WIDTH-1:0] in_operand_b,
  input  logic [WIDTH-1:0] in_operand_c,
  input  logic [WIDTH-1:0] in_operand_d,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] out_divisor
);

  gof_ctrl_t  ctrl;
  gof_flags_t flags;

  gof_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .flags    (flags),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  gof_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_operand_c (in_operand_c),
    .in_operand_d (in_operand_d),
    .out_stall    (out_stall),
    .flags        (flags),
    .out_valid    (out_valid),
    .out_divisor  (out_divisor)
  );

endmodule

[rtl/gof_checker.sv]
module gof_checker
  import gof_pkg::*;
#(
  parameter int WIDTH = GOF_WIDTH_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [WIDTH-1:0] in_operand_a,
  input logic [WIDTH-1:0] in_operand_b,
  input logic [WIDTH-1:0] in_operand_c,
  input logic [WIDTH-1:0] in_operand_d,
  input logic             out_valid,
  input logic             out_stall,
  input logic [WIDTH-1:0] out_divisor
);

  logic [4*WIDTH-1:0] in_bus;
  assign in_bus = {in_operand_a, in_operand_b, in_operand_c, in_operand_d};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_divisor))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_bus))
    else $error("stalled input changed");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in flight");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in flight");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind gcd_of_four_unit gof_checker #(.WIDTH(WIDTH)) u_gof_checker (.*);

[tb/tb_top.sv]
typedef logic [gof_pkg::GOF_WIDTH_DEF-1:0] word_t;

typedef struct packed {
  word_t a;
  word_t b;
  word_t c;
  word_t d;
} quad_t;

typedef struct {
  quad_t ops;
  word_t divisor;
} divisor_due_t;

class divisor_scoreboard;
  divisor_due_t expected_divisors[$];
  int           errors;

  function new();
    errors = 0;
  endfunction

  static function word_t common_divisor(word_t x, word_t y);
    word_t r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function void note_transfer(quad_t q);
    divisor_due_t due;
    due.ops     = q;
    due.divisor = common_divisor(common_divisor(q.a, q.b), common_divisor(q.c, q.d));
    expected_divisors.push_back(due);
  endfunction

  function int pending();
    return expected_divisors.size();
  endfunction

  task report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(word_t got);
    divisor_due_t due;
    if (expected_divisors.size() == 0) begin
      report($sformatf("divisor %0d with nothing outstanding", got));
      return;
    end
    due = expected_divisors.pop_front();
    if (got !== due.divisor) begin
      report($sformatf("gcd(%0d,%0d,%0d,%0d): got %0d, want %0d",
                       due.ops.a, due.ops.b, due.ops.c, due.ops.d, got, due.divisor));
    end
  endtask

  task check_drained();
    if (expected_divisors.size() != 0) begin
      report($sformatf("%0d divisors never transferred", expected_divisors.size()));
    end
  endtask
endclass

module tb_top;
  import gof_pkg::*;

  localparam int W           = GOF_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int HOLD_CYCLES = 400;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [W-1:0] in_operand_a = '0;
  logic [W-1:0] in_operand_b = '0;
  logic [W-1:0] in_operand_c = '0;
  logic [W-1:0] in_operand_d = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_divisor;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  divisor_scoreboard book = new();

  quad_t corners [20] = '{
    '{16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd5,     16'd0,     16'd0,     16'd0},
    '{16'd0,     16'd7,     16'd0,     16'd0},
    '{16'd0,     16'd0,     16'hFFFF,  16'd0},
    '{16'd0,     16'd0,     16'd0,     16'd1},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF},
    '{16'd1,     16'd1,     16'd1,     16'd1},
    '{16'h8000,  16'h8000,  16'h8000,  16'h8000},
    '{16'h8000,  16'h4000,  16'h2000,  16'h1000},
    '{16'd12,    16'd18,    16'd24,    16'd30},
    '{16'd65521, 16'd65519, 16'd0,     16'd65497},
    '{16'hFFFF,  16'hFFFE,  16'd0,     16'd0},
    '{16'd48,    16'd0,     16'd36,    16'd0},
    '{16'h1000,  16'h3000,  16'd0,     16'h5000},
    '{16'd15015, 16'd30030, 16'd45045, 16'd0},
    '{16'd2,     16'd4,     16'd6,     16'd8},
    '{16'd17,    16'd17,    16'd17,    16'd17},
    '{16'hAAAA,  16'h5555,  16'hFFFF,  16'd0},
    '{16'd1,     16'hFFFF,  16'h8000,  16'd0},
    '{16'd0,     16'd0,     16'hA000,  16'hF000}
  };

  gcd_of_four_unit #(.WIDTH(W)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_operand_c (in_operand_c),
    .in_operand_d (in_operand_d),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_divisor  (out_divisor)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[gcd_of_four_unit] ERROR");
    $finish;
  end

  // receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      book.check_result(out_divisor);
    end
  end

  // mostly shared factors so the divisor is often above 1; zeros mixed in
  function automatic quad_t random_quad();
    quad_t q;
    word_t ops [4];
    word_t f;
    int    sel;
    int    k;
    sel = $urandom_range(99);
    k   = $urandom_range(16, 1);
    if (sel < 45) begin
      f = word_t'($urandom_range((1 << k) - 1, 1));
    end else begin
      f = word_t'(1) << $urandom_range(15, 0);
    end
    for (int i = 0; i < 4; i++) begin
      if (sel < 60) begin
        ops[i] = ($urandom_range(99) < 12) ? word_t'(0)
                                            : word_t'(f * $urandom_range(65535 / f, 0));
      end else if (sel < 85) begin
        ops[i] = word_t'($urandom);
      end else begin
        ops[i] = ($urandom_range(99) < 60) ? word_t'(0) : word_t'($urandom);
      end
    end
    q = '{ops[0], ops[1], ops[2], ops[3]};
    return q;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input quad_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operand_a <= q.a;
    in_operand_b <= q.b;
    in_operand_c <= q.c;
    in_operand_d <= q.d;
    do @(posedge clk); while (in_stall !== 1'b0);
    book.note_transfer(q);
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (book.pending() != 0);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 55;
    foreach (corners[i]) send_item(corners[i]);
    repeat (450) send_item(random_quad());
    pause_until_drained();

    send_idle_pct = 55;
    recv_idle_pct = 38;
    repeat (450) send_item(random_quad());
    pause_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (200) send_item(random_quad());
    hold_req = 1'b1;
    repeat (230) send_item(random_quad());
    pause_until_drained();

    repeat (250) @(posedge clk);
    book.check_drained();
    if (book.errors == 0) begin
      $display("[gcd_of_four_unit] OK");
    end else begin
      $display("[gcd_of_four_unit] ERROR");
    end
    $finish;
  end

endmodule
